// ----- design/cods_pkg.sv -----
// Package for the clock offset/drift servo.
// Holds opcodes, register indexes, field widths and shared constants.
// No dependencies.
package cods_pkg;

    // Word field widths
    localparam int TIME_W   = 64;
    localparam int DRIFT_W  = 32;
    localparam int OP_W     = 2;
    localparam int LIMIT_W  = 20;
    localparam int CFG_IW   = 1;

    // Default filter lengths
    localparam int OFFSET_TAPS_DEF = 16;
    localparam int DRIFT_TAPS_DEF  = 16;

    // Nanoseconds per second
    localparam logic [31:0] NS_PER_S = 32'd1000000000;

    // Reset value of the drift limit
    localparam logic [LIMIT_W-1:0] LIMIT_RST = 20'd100000;

    // Item opcodes
    localparam logic [OP_W-1:0] OP_SYNC    = 2'd0;
    localparam logic [OP_W-1:0] OP_QUERY   = 2'd1;
    localparam logic [OP_W-1:0] OP_RESTART = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IW-1:0] REG_SERVO_ENABLE = 1'd0;
    localparam logic [CFG_IW-1:0] REG_DRIFT_LIMIT  = 1'd1;

endpackage

// ----- design/clock_offset_drift_servo.sv -----
// Clock offset/drift servo, top level: sequencer, filter rings, serial mul/div.
// Depends on cods_pkg.
//
//  Channel  Signals                          Word contents (lowest bit first)
//  in       s_tvalid s_tready s_tdata s_tuser master_time, local_clock; opcode in tuser
//  out      m_tvalid m_tready m_tdata         corrected_time, ref_offset_out,
//                                             drift_out, in_sync, sync_lost
//  cfg      cfg_we cfg_index cfg_data         servo_enable, drift_limit
//
// One word at a time. Multiplies run MSB-first, divides are restoring, one
// quotient bit per cycle. A query with the servo enabled takes one multiply
// and one divide; a restart or plain query takes neither. The first sample
// fills the time ring. Later samples write each offset tap and take one divide
// for the offset average; from the fifth sample on, a multiply and divide for
// the drift sample (none on a zero time step) and a divide for the drift average.
// Reset clears all control state; ring contents are written before use.
// A finished word waits in the output register; the next input word is taken
// while it waits, and its result holds until m_tready frees the register.
module clock_offset_drift_servo
    import cods_pkg::*;
#(
    parameter int OFFSET_TAPS = OFFSET_TAPS_DEF,
    parameter int DRIFT_TAPS  = DRIFT_TAPS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    // configuration write port
    input  logic                 cfg_we,
    input  logic [CFG_IW-1:0]    cfg_index,
    input  logic [LIMIT_W-1:0]   cfg_data,
    // input stream
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [127:0]         s_tdata,   // master_time[63:0], local_clock[127:64]
    input  logic [OP_W-1:0]      s_tuser,   // opcode
    // output stream
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [167:0]         m_tdata    // corrected_time[63:0], ref_offset_out[127:64],
                                            // drift_out[159:128], in_sync[160],
                                            // sync_lost[161], zero pad above
);

    localparam int OIW = (OFFSET_TAPS > 1) ? $clog2(OFFSET_TAPS) : 1;
    localparam int DIW = (DRIFT_TAPS > 1) ? $clog2(DRIFT_TAPS) : 1;
    localparam int OFW = $clog2(OFFSET_TAPS + 1);
    localparam int DFW = $clog2(DRIFT_TAPS + 1);
    localparam int DSUM_W = DRIFT_W + 1 + $clog2(DRIFT_TAPS + 1);
    localparam int PROD_W = TIME_W + 32;
    localparam logic [OIW-1:0] OIDX_LAST = OIW'(OFFSET_TAPS - 1);
    localparam logic [DIW-1:0] DIDX_LAST = DIW'(DRIFT_TAPS - 1);
    localparam logic [OFW-1:0] OFILL_MAX = OFW'(OFFSET_TAPS);
    localparam logic [DFW-1:0] DFILL_MAX = DFW'(DRIFT_TAPS);
    localparam logic [6:0] DIV_LAST = 7'(PROD_W - 1);

    typedef enum logic [4:0] {
        ST_IDLE, ST_TFILL, ST_ORD, ST_OUPD, ST_ODIV, ST_OFIN, ST_TWR, ST_TRD,
        ST_TMID, ST_SPREP, ST_SFIN, ST_DSTART, ST_DRD, ST_DUPD, ST_DDIV,
        ST_DFIN, ST_LOCK, ST_MUL, ST_DIV, ST_QFIN, ST_DONE
    } state_t;

    state_t state_reg;
    state_t ret_reg;

    // configuration
    logic                 enable_reg;
    logic [LIMIT_W-1:0]   limit_reg;

    // current word
    logic [TIME_W-1:0]    local_reg;
    logic [TIME_W-1:0]    val_reg;
    logic [TIME_W-1:0]    corr_reg;
    logic                 lost_reg;

    // servo state
    logic [TIME_W-1:0]    ref_offset_reg;
    logic [TIME_W-1:0]    ref_time_reg;
    logic [DRIFT_W-1:0]   drift_reg;
    logic [TIME_W-1:0]    last_local_reg;
    logic [TIME_W-1:0]    last_offset_reg;
    logic [2:0]           sc_reg;
    logic                 locked_reg;

    // offset filter
    logic [TIME_W-1:0]    osum_reg;
    logic [OIW-1:0]       oidx_reg;
    logic [OFW-1:0]       ofill_reg;
    logic [OFW-1:0]       ocnt_reg;
    logic                 ofull_reg;
    logic [TIME_W-1:0]    ord_reg;
    logic [TIME_W-1:0]    oring [OFFSET_TAPS];

    // time ring
    logic [OIW-1:0]       tidx_reg;
    logic [OIW-1:0]       tcnt_reg;
    logic [TIME_W-1:0]    trd_reg;
    logic [TIME_W-1:0]    tring [OFFSET_TAPS];

    // drift filter
    logic [DSUM_W-1:0]    dsum_reg;
    logic [DIW-1:0]       didx_reg;
    logic [DFW-1:0]       dfill_reg;
    logic [DFW-1:0]       dcnt_reg;
    logic                 dfull_reg;
    logic [DRIFT_W-1:0]   samp_reg;
    logic [DRIFT_W-1:0]   drd_reg;
    logic [DRIFT_W-1:0]   dring [DRIFT_TAPS];

    // serial multiplier and divider
    logic [TIME_W-1:0]    mcand_reg;
    logic [31:0]          mpl_reg;
    logic [PROD_W-1:0]    acc_reg;
    logic [4:0]           mcnt_reg;
    logic [PROD_W-1:0]    dvd_reg;
    logic [PROD_W-1:0]    quo_reg;
    logic [TIME_W-1:0]    rem_reg;
    logic [TIME_W-1:0]    dvs_reg;
    logic [6:0]           qcnt_reg;
    logic                 sgn_reg;

    // output register
    logic                 m_valid_reg;
    logic [167:0]         m_data_reg;

    logic                 in_acc;
    logic                 out_load;
    logic [TIME_W-1:0]    s_master;
    logic [TIME_W-1:0]    s_local;
    logic [PROD_W-1:0]    acc_nx;
    logic [TIME_W:0]      div_r2;
    logic                 div_ge;
    logic [TIME_W-1:0]    div_rem_nx;
    logic [TIME_W-1:0]    osum_mag;
    logic [DSUM_W-1:0]    dsum_mag;
    logic [DSUM_W-1:0]    dsum_nx;
    logic [TIME_W-1:0]    mid_val;
    logic [TIME_W-1:0]    dt_val;
    logic [TIME_W-1:0]    diff_val;
    logic [TIME_W-1:0]    td_val;
    logic [DRIFT_W-1:0]   drift_mag;
    logic [PROD_W-1:0]    sat_lim;
    logic [DRIFT_W-1:0]   sat_q;
    logic [TIME_W-1:0]    qlo;
    logic                 lock_ok;
    logic signed [DRIFT_W:0] drift_x;
    logic signed [DRIFT_W:0] limit_x;

    assign s_master = s_tdata[63:0];
    assign s_local  = s_tdata[127:64];
    assign s_tready = (state_reg == ST_IDLE);
    assign in_acc   = s_tvalid && s_tready;
    assign out_load = (state_reg == ST_DONE) && (!m_valid_reg || m_tready);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // datapath helpers
    always_comb
    begin
        acc_nx     = {acc_reg[PROD_W-2:0], 1'b0} +
                     (mpl_reg[31] ? {32'b0, mcand_reg} : {PROD_W{1'b0}});
        div_r2     = {rem_reg, dvd_reg[PROD_W-1]};
        div_ge     = div_r2 >= {1'b0, dvs_reg};
        div_rem_nx = div_ge ? TIME_W'(div_r2 - {1'b0, dvs_reg}) : div_r2[TIME_W-1:0];
        osum_mag   = osum_reg[TIME_W-1] ? (~osum_reg + 1'b1) : osum_reg;
        dsum_mag   = dsum_reg[DSUM_W-1] ? (~dsum_reg + 1'b1) : dsum_reg;
        dsum_nx    = dsum_reg
                     - (dfull_reg ? {DSUM_W{1'b0}}
                                  : {{(DSUM_W-DRIFT_W){drd_reg[DRIFT_W-1]}}, drd_reg})
                     + {{(DSUM_W-DRIFT_W){samp_reg[DRIFT_W-1]}}, samp_reg};
        mid_val    = trd_reg + ((local_reg - trd_reg) >> 1);
        dt_val     = local_reg - last_local_reg;
        diff_val   = ref_offset_reg - last_offset_reg;
        td_val     = s_local - ref_time_reg;
        drift_mag  = drift_reg[DRIFT_W-1] ? (~drift_reg + 1'b1) : drift_reg;
        sat_lim    = sgn_reg ? PROD_W'(33'h080000000) : PROD_W'(33'h07fffffff);
        sat_q      = (quo_reg > sat_lim) ? sat_lim[DRIFT_W-1:0] : quo_reg[DRIFT_W-1:0];
        qlo        = sgn_reg ? (~quo_reg[TIME_W-1:0] + 1'b1) : quo_reg[TIME_W-1:0];
        drift_x    = {drift_reg[DRIFT_W-1], drift_reg};
        limit_x    = (DRIFT_W+1)'({1'b0, limit_reg});
        lock_ok    = (drift_x < limit_x) && (drift_x > -limit_x);
    end

    // offset ring
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_OUPD)
        begin
            oring[oidx_reg] <= val_reg;
        end
        ord_reg <= oring[oidx_reg];
    end

    // time ring
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_TFILL)
        begin
            tring[tcnt_reg] <= local_reg;
        end
        else if (state_reg == ST_TWR)
        begin
            tring[tidx_reg] <= local_reg;
        end
        trd_reg <= tring[tidx_reg];
    end

    // drift ring
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_DUPD)
        begin
            dring[didx_reg] <= samp_reg;
        end
        drd_reg <= dring[didx_reg];
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg <= 1'b0;
            limit_reg  <= LIMIT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_SERVO_ENABLE: enable_reg <= cfg_data[0];
                REG_DRIFT_LIMIT:  limit_reg  <= cfg_data;
                default:          ;
            endcase
        end
    end

    // sequencer and servo state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            ret_reg         <= ST_IDLE;
            ref_offset_reg  <= '0;
            ref_time_reg    <= '0;
            drift_reg       <= '0;
            last_local_reg  <= '0;
            last_offset_reg <= '0;
            sc_reg          <= '0;
            locked_reg      <= 1'b0;
            osum_reg        <= '0;
            oidx_reg        <= '0;
            ofill_reg       <= OFILL_MAX;
            ocnt_reg        <= '0;
            ofull_reg       <= 1'b0;
            tidx_reg        <= '0;
            tcnt_reg        <= '0;
            dsum_reg        <= '0;
            didx_reg        <= '0;
            dfill_reg       <= DFILL_MAX;
            dcnt_reg        <= '0;
            dfull_reg       <= 1'b0;
            mcnt_reg        <= '0;
            qcnt_reg        <= '0;
            m_valid_reg     <= 1'b0;
        end
        else
        begin
            if (out_load)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_valid_reg && m_tready)
            begin
                m_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (in_acc)
                    begin
                        local_reg <= s_local;
                        val_reg   <= s_local - s_master;
                        corr_reg  <= (s_tuser == OP_QUERY && !enable_reg) ? s_local : '0;
                        lost_reg  <= 1'b0;
                        case (s_tuser)
                            OP_SYNC:
                            begin
                                if (sc_reg == 3'd0)
                                begin
                                    // first sample: restart filters, fill time ring
                                    ref_offset_reg <= s_local - s_master;
                                    oidx_reg       <= '0;
                                    ofill_reg      <= OFILL_MAX;
                                    didx_reg       <= '0;
                                    dfill_reg      <= DFILL_MAX;
                                    tidx_reg       <= '0;
                                    tcnt_reg       <= '0;
                                    drift_reg      <= '0;
                                    last_local_reg <= s_local;
                                    locked_reg     <= 1'b0;
                                    sc_reg         <= 3'd1;
                                    state_reg      <= ST_TFILL;
                                end
                                else
                                begin
                                    ofull_reg <= (ofill_reg == OFILL_MAX);
                                    if (ofill_reg == OFILL_MAX)
                                    begin
                                        osum_reg <= '0;
                                    end
                                    ocnt_reg  <= '0;
                                    state_reg <= ST_ORD;
                                end
                            end
                            OP_QUERY:
                            begin
                                if (enable_reg)
                                begin
                                    mcand_reg <= td_val[TIME_W-1] ? (~td_val + 1'b1) : td_val;
                                    mpl_reg   <= drift_mag;
                                    sgn_reg   <= td_val[TIME_W-1] ^ drift_reg[DRIFT_W-1];
                                    dvs_reg   <= TIME_W'(NS_PER_S);
                                    acc_reg   <= '0;
                                    mcnt_reg  <= '0;
                                    ret_reg   <= ST_QFIN;
                                    state_reg <= ST_MUL;
                                end
                                else
                                begin
                                    state_reg <= ST_DONE;
                                end
                            end
                            OP_RESTART:
                            begin
                                locked_reg <= 1'b0;
                                sc_reg     <= '0;
                                state_reg  <= ST_DONE;
                            end
                            default: state_reg <= ST_DONE;
                        endcase
                    end
                end

                ST_TFILL:
                begin
                    tcnt_reg <= (tcnt_reg == OIDX_LAST) ? '0 : tcnt_reg + 1'b1;
                    if (tcnt_reg == OIDX_LAST)
                    begin
                        state_reg <= ST_DONE;
                    end
                end

                // offset moving average, each tap read (ST_ORD) then updated (ST_OUPD)
                ST_ORD:
                begin
                    state_reg <= ST_OUPD;
                end

                ST_OUPD:
                begin
                    osum_reg <= osum_reg - (ofull_reg ? '0 : ord_reg) + val_reg;
                    oidx_reg <= (oidx_reg == OIDX_LAST) ? '0 : oidx_reg + 1'b1;
                    ocnt_reg <= ocnt_reg + 1'b1;
                    state_reg <= (OFW'(ocnt_reg + 1'b1) == ofill_reg) ? ST_ODIV : ST_ORD;
                end

                ST_ODIV:
                begin
                    if (ofill_reg > OFW'(1))
                    begin
                        ofill_reg <= ofill_reg >> 1;
                    end
                    sgn_reg   <= osum_reg[TIME_W-1];
                    dvd_reg   <= {32'b0, osum_mag};
                    dvs_reg   <= TIME_W'(OFFSET_TAPS);
                    rem_reg   <= '0;
                    qcnt_reg  <= '0;
                    ret_reg   <= ST_OFIN;
                    state_reg <= ST_DIV;
                end

                ST_OFIN:
                begin
                    ref_offset_reg <= qlo;
                    state_reg      <= ST_TWR;
                end

                // midpoint reference time
                ST_TWR:
                begin
                    tidx_reg  <= (tidx_reg == OIDX_LAST) ? '0 : tidx_reg + 1'b1;
                    state_reg <= ST_TRD;
                end

                ST_TRD:
                begin
                    state_reg <= ST_TMID;
                end

                ST_TMID:
                begin
                    ref_time_reg <= mid_val;
                    state_reg    <= (sc_reg > 3'd3) ? ST_SPREP : ST_LOCK;
                end

                // drift sample: offset change times 1e9 over time step
                ST_SPREP:
                begin
                    if (dt_val == '0)
                    begin
                        samp_reg  <= '0;
                        state_reg <= ST_DSTART;
                    end
                    else
                    begin
                        sgn_reg   <= diff_val[TIME_W-1];
                        mcand_reg <= diff_val[TIME_W-1] ? (~diff_val + 1'b1) : diff_val;
                        mpl_reg   <= NS_PER_S;
                        dvs_reg   <= dt_val;
                        acc_reg   <= '0;
                        mcnt_reg  <= '0;
                        ret_reg   <= ST_SFIN;
                        state_reg <= ST_MUL;
                    end
                end

                ST_SFIN:
                begin
                    samp_reg  <= sgn_reg ? (~sat_q + 1'b1) : sat_q;
                    state_reg <= ST_DSTART;
                end

                // drift moving average
                ST_DSTART:
                begin
                    dfull_reg <= (dfill_reg == DFILL_MAX);
                    if (dfill_reg == DFILL_MAX)
                    begin
                        dsum_reg <= '0;
                    end
                    dcnt_reg  <= '0;
                    state_reg <= ST_DRD;
                end

                ST_DRD:
                begin
                    state_reg <= ST_DUPD;
                end

                ST_DUPD:
                begin
                    dsum_reg <= dsum_nx;
                    didx_reg <= (didx_reg == DIDX_LAST) ? '0 : didx_reg + 1'b1;
                    dcnt_reg <= dcnt_reg + 1'b1;
                    state_reg <= (DFW'(dcnt_reg + 1'b1) == dfill_reg) ? ST_DDIV : ST_DRD;
                end

                ST_DDIV:
                begin
                    if (dfill_reg > DFW'(1))
                    begin
                        dfill_reg <= dfill_reg >> 1;
                    end
                    sgn_reg   <= dsum_reg[DSUM_W-1];
                    dvd_reg   <= PROD_W'(dsum_mag);
                    dvs_reg   <= TIME_W'(DRIFT_TAPS);
                    rem_reg   <= '0;
                    qcnt_reg  <= '0;
                    ret_reg   <= ST_DFIN;
                    state_reg <= ST_DIV;
                end

                ST_DFIN:
                begin
                    drift_reg <= qlo[DRIFT_W-1:0];
                    state_reg <= ST_LOCK;
                end

                // lock decision and history update
                ST_LOCK:
                begin
                    state_reg <= ST_DONE;
                    if (sc_reg == 3'd7 && !lock_ok && locked_reg)
                    begin
                        locked_reg <= 1'b0;
                        sc_reg     <= '0;
                        lost_reg   <= 1'b1;
                    end
                    else
                    begin
                        if (sc_reg == 3'd7 && lock_ok)
                        begin
                            locked_reg <= 1'b1;
                        end
                        last_local_reg  <= local_reg;
                        last_offset_reg <= ref_offset_reg;
                        if (sc_reg != 3'd7)
                        begin
                            sc_reg <= sc_reg + 1'b1;
                        end
                    end
                end

                // shift-add multiply, multiplier MSB first
                ST_MUL:
                begin
                    acc_reg  <= acc_nx;
                    mpl_reg  <= {mpl_reg[30:0], 1'b0};
                    mcnt_reg <= mcnt_reg + 1'b1;
                    if (mcnt_reg == 5'd31)
                    begin
                        dvd_reg   <= acc_nx;
                        rem_reg   <= '0;
                        qcnt_reg  <= '0;
                        state_reg <= ST_DIV;
                    end
                end

                // restoring divide, one quotient bit per cycle
                ST_DIV:
                begin
                    rem_reg  <= div_rem_nx;
                    dvd_reg  <= {dvd_reg[PROD_W-2:0], 1'b0};
                    quo_reg  <= {quo_reg[PROD_W-2:0], div_ge};
                    qcnt_reg <= qcnt_reg + 1'b1;
                    if (qcnt_reg == DIV_LAST)
                    begin
                        state_reg <= ret_reg;
                    end
                end

                ST_QFIN:
                begin
                    corr_reg  <= local_reg - (ref_offset_reg + qlo);
                    state_reg <= ST_DONE;
                end

                ST_DONE:
                begin
                    if (out_load)
                    begin
                        m_data_reg  <= {6'b0, lost_reg, locked_reg, drift_reg,
                                        ref_offset_reg, corr_reg};
                        state_reg   <= ST_IDLE;
                    end
                end

                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

// ----- test/clock_offset_drift_servo_test.sv -----
// Self-checking testbench for clock_offset_drift_servo: drives sync samples, queries and
// restarts, predicts each result word in-line, and compares field by field.
// Depends on cods_pkg and the clock_offset_drift_servo RTL.
`timescale 1ns / 1ps

module clock_offset_drift_servo_test;
    import cods_pkg::*;

    localparam int TAPS      = 16;
    localparam int WDOG_MAX  = 20000;
    localparam int HOLD_LONG = 3000;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [63:0]       mtime;
        logic [63:0]       ltime;
    } servo_word_t;

    typedef struct packed {
        logic [63:0] corr;
        logic [63:0] offs;
        logic [31:0] drift;
        logic        locked;
        logic        lost;
    } servo_result_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IW-1:0] cfg_index;
    logic [LIMIT_W-1:0] cfg_data;
    logic s_tvalid;
    logic s_tready;
    logic [127:0] s_tdata;   // master_time, local_clock
    logic [OP_W-1:0] s_tuser; // opcode
    logic m_tvalid;
    logic m_tready;
    logic [167:0] m_tdata;   // corrected_time, ref_offset_out, drift_out, in_sync, sync_lost

    clock_offset_drift_servo dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    servo_word_t   pending_words[$];
    servo_result_t expected_results[$];
    int  fail_count = 0;
    int  idle_mode = 0;     // 0 none, 1 sender, 2 receiver, 3 both
    int  hold_request = 0;
    int  hold_count = 0;
    int  quiet_cycles = 0;
    logic in_taken = 1'b0;

    // servo model state
    logic        en_q;
    logic [19:0] limit_q;
    logic [63:0] avg_ring[2][TAPS];
    logic [63:0] avg_sum[2];
    int          avg_idx[2];
    int          avg_fill[2];
    logic [63:0] time_ring[TAPS];
    int          time_idx;
    logic [63:0] ref_off, ref_tm, last_loc, last_off;
    logic signed [63:0] drift_q;
    int          samples;
    logic        lock_q;

    function automatic logic [63:0] div_taps(logic [63:0] s);
        logic [63:0] m;
        m = s[63] ? -s : s;
        m = m / TAPS;
        return s[63] ? -m : m;
    endfunction

    // moving average with fast-start fill; k selects offset (0) or drift (1)
    function automatic logic [63:0] average_in(int k, logic [63:0] v);
        int i;
        for (int n = 0; n < avg_fill[k]; n++)
        begin
            i = (avg_idx[k] >= TAPS) ? 0 : avg_idx[k];
            avg_sum[k] = avg_sum[k] - avg_ring[k][i] + v;
            avg_ring[k][i] = v;
            i++;
            avg_idx[k] = (i >= TAPS) ? 0 : i;
        end
        if (avg_fill[k] > 1)
            avg_fill[k] = avg_fill[k] / 2;
        return div_taps(avg_sum[k]);
    endfunction

    function automatic logic [63:0] midpoint_in(logic [63:0] v);
        int i;
        i = (time_idx >= TAPS) ? 0 : time_idx;
        time_ring[i] = v;
        i++;
        if (i >= TAPS)
            i = 0;
        time_idx = i;
        return time_ring[i] + (v - time_ring[i]) / 2;
    endfunction

    function automatic logic [63:0] drift_ppb(logic [63:0] loc);
        logic [63:0]  dt, diff, m, lim;
        logic [127:0] q;
        dt = loc - last_loc;
        if (dt == 0)
            return 64'd0;
        diff = ref_off - last_off;
        m = diff[63] ? -diff : diff;
        q = ({64'd0, m} * 128'd1000000000) / {64'd0, dt};
        lim = diff[63] ? 64'h80000000 : 64'h7FFFFFFF;
        if (q > {64'd0, lim})
            q = {64'd0, lim};
        return diff[63] ? -q[63:0] : q[63:0];
    endfunction

    function automatic void servo_clear();
        en_q = 1'b0;
        limit_q = LIMIT_RST;
        for (int k = 0; k < 2; k++)
        begin
            avg_sum[k] = 0;
            avg_idx[k] = 0;
            avg_fill[k] = TAPS;
            for (int i = 0; i < TAPS; i++)
                avg_ring[k][i] = 0;
        end
        for (int i = 0; i < TAPS; i++)
            time_ring[i] = 0;
        time_idx = 0;
        ref_off = 0; ref_tm = 0; drift_q = 0; last_loc = 0; last_off = 0;
        samples = 0; lock_q = 1'b0;
    endfunction

    function automatic servo_result_t servo_predict(servo_word_t w);
        servo_result_t r;
        logic [63:0]  td, tm, dm, ql;
        logic [127:0] p;
        logic signed [63:0] lim;
        logic restarted;
        r = '0;
        restarted = 1'b0;
        if (w.op == OP_SYNC)
        begin
            if (samples == 0)
            begin
                ref_off = w.ltime - w.mtime;
                for (int k = 0; k < 2; k++)
                begin
                    avg_sum[k] = 0;
                    avg_idx[k] = 0;
                    avg_fill[k] = TAPS;
                    for (int i = 0; i < TAPS; i++)
                        avg_ring[k][i] = 0;
                end
                for (int i = 0; i < TAPS; i++)
                    time_ring[i] = w.ltime;
                time_idx = 0;
                drift_q = 0;
                last_loc = w.ltime;
                lock_q = 1'b0;
                samples = 1;
            end
            else
            begin
                ref_off = average_in(0, w.ltime - w.mtime);
                ref_tm = midpoint_in(w.ltime);
                if (samples > 3)
                begin
                    drift_q = average_in(1, drift_ppb(w.ltime));
                    if (samples > 6)
                    begin
                        lim = {44'd0, limit_q};
                        if (drift_q < lim && drift_q > -lim)
                            lock_q = 1'b1;
                        else if (lock_q)
                        begin
                            lock_q = 1'b0;
                            samples = 0;
                            r.lost = 1'b1;
                            restarted = 1'b1;
                        end
                    end
                end
                if (!restarted)
                begin
                    last_loc = w.ltime;
                    last_off = ref_off;
                    if (samples < 7)
                        samples++;
                end
            end
        end
        else if (w.op == OP_QUERY)
        begin
            if (!en_q)
                r.corr = w.ltime;
            else
            begin
                td = w.ltime - ref_tm;
                tm = td[63] ? -td : td;
                dm = drift_q[63] ? -drift_q : drift_q;
                p = ({64'd0, tm} * {64'd0, dm}) / 128'd1000000000;
                ql = (td[63] != drift_q[63]) ? -p[63:0] : p[63:0];
                r.corr = w.ltime - (ref_off + ql);
            end
        end
        else if (w.op == OP_RESTART)
        begin
            lock_q = 1'b0;
            samples = 0;
        end
        r.offs = ref_off;
        r.drift = drift_q[31:0];
        r.locked = lock_q;
        return r;
    endfunction

    // input acceptance and prediction
    always @(posedge clk)
    begin
        in_taken <= s_tvalid && s_tready;
        if (s_tvalid && s_tready)
            expected_results.push_back(servo_predict({s_tuser, s_tdata[63:0],
                                                      s_tdata[127:64]}));
    end

    // input word driver
    always @(negedge clk)
    begin
        if (rst_n && (!s_tvalid || in_taken))
        begin
            if (pending_words.size() > 0 &&
                !((idle_mode == 1 || idle_mode == 3) &&
                  $urandom_range(99) < (idle_mode == 1 ? 54 : 26)))
            begin
                s_tvalid <= 1'b1;
                s_tuser  <= pending_words[0].op;
                s_tdata  <= {pending_words[0].ltime, pending_words[0].mtime};
                void'(pending_words.pop_front());
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // receiver backpressure, with a long hold-off on request
    always @(negedge clk)
    begin
        if (hold_request > 0 && hold_count == 0)
        begin
            hold_count <= hold_request;
            hold_request <= 0;
            m_tready <= 1'b0;
        end
        else if (hold_count > 0)
        begin
            hold_count <= hold_count - 1;
            m_tready <= 1'b0;
        end
        else if (idle_mode == 2 || idle_mode == 3)
            m_tready <= $urandom_range(99) >= (idle_mode == 2 ? 54 : 26);
        else
            m_tready <= 1'b1;
    end

    // result check and watchdog
    always @(posedge clk)
    begin
        servo_result_t e;
        if (m_tvalid && m_tready)
        begin
            if (expected_results.size() == 0)
            begin
                $display("%0t: result word with none expected: %h", $time, m_tdata);
                fail_count++;
            end
            else
            begin
                e = expected_results.pop_front();
                if (m_tdata[63:0] !== e.corr)
                begin
                    $display("%0t: corrected_time exp %h got %h", $time, e.corr,
                             m_tdata[63:0]);
                    fail_count++;
                end
                if (m_tdata[127:64] !== e.offs)
                begin
                    $display("%0t: ref_offset_out exp %h got %h", $time, e.offs,
                             m_tdata[127:64]);
                    fail_count++;
                end
                if (m_tdata[159:128] !== e.drift)
                begin
                    $display("%0t: drift_out exp %h got %h", $time, e.drift,
                             m_tdata[159:128]);
                    fail_count++;
                end
                if (m_tdata[160] !== e.locked)
                begin
                    $display("%0t: in_sync exp %b got %b", $time, e.locked, m_tdata[160]);
                    fail_count++;
                end
                if (m_tdata[161] !== e.lost)
                begin
                    $display("%0t: sync_lost exp %b got %b", $time, e.lost, m_tdata[161]);
                    fail_count++;
                end
            end
        end
        if ((m_tvalid && m_tready) || (s_tvalid && s_tready) || cfg_we)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WDOG_MAX)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic void add_word(logic [1:0] op, logic [63:0] mt, logic [63:0] lt);
        servo_word_t w;
        w.op = op;
        w.mtime = mt;
        w.ltime = lt;
        pending_words.push_back(w);
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // restart, then a plausible run of sync samples with queries mixed in
    function automatic void add_sync_run();
        longint base, off, ppb, mt, lt;
        int n;
        base = longint'({$urandom_range(65535), $urandom});
        off = longint'($urandom_range(2000000)) - 1000000;
        ppb = longint'($urandom_range(120000)) - 60000;
        n = $urandom_range(7, 14);
        add_word(OP_RESTART, rand64(), rand64());
        for (int i = 0; i < n; i++)
        begin
            mt = base + i * (64'd1000000000 + $urandom_range(2000));
            lt = mt + off + ppb * i + $urandom_range(200);
            add_word(OP_SYNC, mt, lt);
            if ($urandom_range(3) == 0)
                add_word(OP_QUERY, rand64(), lt + $urandom_range(2000000000));
        end
        // sometimes break the lock with a big offset jump
        if ($urandom_range(2) == 0)
            add_word(OP_SYNC, mt + 10, lt + 10 + 64'd500000000);
        add_word(OP_QUERY, rand64(), lt + $urandom_range(1000000));
    endfunction

    task automatic write_reg(logic [CFG_IW-1:0] idx, logic [LIMIT_W-1:0] val);
        @(negedge clk);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = val;
        if (idx == REG_SERVO_ENABLE)
            en_q = val[0];
        else
            limit_q = val;
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task automatic drain();
        wait (pending_words.size() == 0 && !s_tvalid && expected_results.size() == 0);
        repeat (500) @(posedge clk);
    endtask

    initial
    begin
        int count;
        logic [19:0] limits[6];
        logic        enables[6];
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        m_tready = 1'b1;
        servo_clear();
        rst_n = 1'b0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        limits  = '{20'd100000, 20'd0, 20'd1000000, 20'd100000, 20'd5000, 20'hFFFFF};
        enables = '{1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0};
        for (int ph = 0; ph < 6; ph++)
        begin
            idle_mode = ph % 4;
            write_reg(REG_SERVO_ENABLE, {19'd0, enables[ph]});
            write_reg(REG_DRIFT_LIMIT, ph == 4 ? 20'($urandom_range(1000000)) : limits[ph]);
            if (ph == 0)
            begin
                // directed: extremes, zero time step, saturation, odd opcode
                add_word(OP_QUERY, '0, '0);
                add_word(OP_SYNC, '0, '0);
                add_word(OP_SYNC, '1, '1);
                add_word(OP_SYNC, '0, '1);
                for (int i = 0; i < 5; i++)
                    add_word(OP_SYNC, 64'd1000 * i, 64'd5000);
                add_word(OP_SYNC, 64'd7, 64'h7FFFFFFFFFFFFFFF);
                add_word(OP_SYNC, 64'd8, 64'h7FFFFFFFFFFFFFFF + 1);
                add_word(OP_QUERY, '0, '1);
                add_word(OP_QUERY, '1, 64'h8000000000000000);
                add_word(2'd3, '1, '1);
                add_word(OP_RESTART, '0, '0);
                add_word(OP_SYNC, 64'd100, 64'd50);
                add_word(OP_QUERY, '0, 64'd60);
            end
            if (ph == 2)
                hold_request = HOLD_LONG;
            count = 0;
            while (count < 200)
            begin
                if ($urandom_range(9) < 7)
                    add_sync_run();
                else
                    for (int i = 0; i < 4; i++)
                        add_word(2'($urandom_range(3)), rand64(), rand64());
                count = count + 18;
                if (ph == 1 && count > 70 && count < 90)
                begin
                    // sender pauses until every result has come back
                    wait (pending_words.size() == 0 && !s_tvalid &&
                          expected_results.size() == 0);
                end
            end
            drain();
        end

        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ----- clock_offset_drift_servo.f -----
design/cods_pkg.sv
design/clock_offset_drift_servo.sv
test/clock_offset_drift_servo_test.sv
